FILE: design/bpq_pkg.sv
// Shared constants, codes and state types of the breakpoint table interpolator.
// Depends on nothing; every other design file except bpq_ram imports it.
package bpq_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DW         = 32;
  localparam int DIFF_W     = DW + 1;
  localparam int ENTRY_W    = 2 * DW;
  localparam int WW         = 136;
  localparam int QCAP_BIT   = 40;
  localparam int QW         = QCAP_BIT + 2;
  localparam int SUM_W      = QW + 1;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_AW-3:0] REG_POINT_COUNT = '0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_N1,
    S_SCAN,
    S_DECIDE,
    S_TRI,
    S_EVAL,
    S_MSTART,
    S_MWAIT,
    S_DSTART,
    S_DWAIT,
    S_FIN,
    S_HOLD
  } state_t;

  typedef enum logic [2:0] {
    OP_LIN,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_M4,
    OP_M5,
    OP_M6,
    OP_M7
  } op_t;

endpackage

FILE: design/bpq_in_if.sv
// Input channel of the interpolator: load and query items with valid/ready.
// Depends on bpq_pkg.
interface bpq_in_if import bpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [IDX_W-1:0]        point_index;
  logic signed [DW-1:0]    point_x;
  logic signed [DW-1:0]    point_y;
  logic signed [DW-1:0]    query_x;

  modport source(output valid, kind, point_index, point_x, point_y, query_x, input ready);
  modport sink(input valid, kind, point_index, point_x, point_y, query_x, output ready);
endinterface

FILE: design/bpq_out_if.sv
// Result channel of the interpolator with valid/ready.
// Depends on bpq_pkg.
interface bpq_out_if import bpq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] result_y;
  logic                 saturated;

  modport source(output valid, result_y, saturated, input ready);
  modport sink(input valid, result_y, saturated, output ready);
endinterface

FILE: design/breakpoint_table_quadratic_interp_top.sv
// Breakpoint table interpolator: table RAM, scan sequencer, multiplier, divider.
// A load writes one table entry. A query with four or more points scans the table RAM,
// then runs sequential multiplies and a divide where needed: a linear answer takes one
// multiply, a quadratic one seven (one to three points skip the scan). One item is in
// work at a time.
// Synchronous active-low reset clears control and sets point_count to 1.
module breakpoint_table_quadratic_interp_top import bpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bpq_in_if.sink            in_ch,
  bpq_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [DW-1:0] a,
                                                      input logic signed [DW-1:0] b);
    sdiff = $signed({a[DW-1], a}) - $signed({b[DW-1], b});
  endfunction

  state_t state_r, state_nxt;
  op_t    op_r;

  logic [CNT_W-1:0] point_count_r;
  logic [CNT_W-1:0] n_eff, n_r, k_r, dtag_r, tag_m2, nm1, km1;
  logic             dval_r;
  logic             cfg_wr;

  logic signed [DW-1:0] q_r, x0_r, y0_r, xl_r, yl_r, prev_x_r, hit_y_r;
  logic signed [DW-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, xb_r, yb_r, res_y_r;
  logic                 up_r, hit_r, selv_r, res_sat_r;
  logic [IDX_W-1:0]     sel_r, ia_r, ib_r, ic_r, sel_a;

  logic                 out_valid_r, out_sat_r, load_out;
  logic signed [DW-1:0] out_y_r;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]   rdata;
  logic signed [DW-1:0] rx, ry;
  logic                 in_acc;

  logic signed [WW-1:0]     m1_r, m3_r, acc_r, num_r, den_r;
  logic signed [WW-1:0]     mul_a, mul_p;
  logic signed [DIFF_W-1:0] mul_b;
  logic                     mul_start, mul_done;
  logic                     div_start, div_done;
  logic signed [QW-1:0]     div_quo;

  logic                 lo_clamp, hi_clamp, dec_direct;
  logic signed [DW-1:0] dec_y;
  logic                 use_lin, eval_direct;
  logic signed [DW-1:0] lxb, lyb, eval_y;
  logic signed [SUM_W-1:0] fin_sum;
  logic                 fin_ovf;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_POINT_COUNT) ?
                      {{(CFG_DW-CNT_W){1'b0}}, point_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= CNT_W'(1);
    end else if (cfg_wr && cfg_paddr[CFG_AW-1:2] == REG_POINT_COUNT) begin
      point_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (point_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (point_count_r > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = point_count_r;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  bpq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (in_acc && in_ch.kind == KIND_LOAD),
    .waddr (in_ch.point_index),
    .wdata ({in_ch.point_x, in_ch.point_y}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign rx     = rdata[ENTRY_W-1:DW];
  assign ry     = rdata[DW-1:0];
  assign nm1    = n_r - 1'b1;
  assign km1    = k_r - 1'b1;
  assign tag_m2 = dtag_r - CNT_W'(2);

  // Decision after the scan.
  assign lo_clamp = up_r ? (q_r < x0_r) : (q_r > x0_r);
  assign hi_clamp = up_r ? (q_r > xl_r) : (q_r < xl_r);
  assign sel_a    = (sel_r == '0) ? '0 : sel_r - 1'b1;

  always_comb begin
    dec_direct = 1'b1;
    priority if (lo_clamp || q_r == x0_r) begin
      dec_y = y0_r;
    end else if (hi_clamp) begin
      dec_y = yl_r;
    end else if (hit_r) begin
      dec_y = hit_y_r;
    end else if (!selv_r) begin
      dec_y = yl_r;
    end else begin
      dec_y      = yl_r;
      dec_direct = 1'b0;
    end
  end

  // Triple evaluation: end clamps, repeated abscissas, linear clamps.
  always_comb begin
    use_lin = (x1_r == x2_r) || (x1_r == x3_r) || (x2_r == x3_r);
    if (x1_r != x2_r && x1_r == x3_r) begin
      lxb = x2_r;
      lyb = y2_r;
    end else begin
      lxb = x3_r;
      lyb = y3_r;
    end
    eval_direct = 1'b1;
    priority if (x1_r < x3_r && q_r > x3_r) begin
      eval_y = y3_r;
    end else if (x1_r < x3_r && q_r < x1_r) begin
      eval_y = y1_r;
    end else if (x1_r > x3_r && q_r < x3_r) begin
      eval_y = y3_r;
    end else if (x1_r > x3_r && q_r > x1_r) begin
      eval_y = y1_r;
    end else if (!use_lin) begin
      eval_y      = y1_r;
      eval_direct = 1'b0;
    end else if (x1_r < lxb && q_r > lxb) begin
      eval_y = lyb;
    end else if (x1_r < lxb && q_r < x1_r) begin
      eval_y = y1_r;
    end else if (x1_r > lxb && q_r < lxb) begin
      eval_y = lyb;
    end else if (x1_r > lxb && q_r > x1_r) begin
      eval_y = y1_r;
    end else if (x1_r == lxb) begin
      eval_y = y1_r;
    end else begin
      eval_y      = y1_r;
      eval_direct = 1'b0;
    end
  end

  always_comb begin
    unique case (op_r)
      OP_LIN: begin
        mul_a = WW'(sdiff(yb_r, y1_r));
        mul_b = sdiff(q_r, x1_r);
      end
      OP_M1: begin
        mul_a = WW'(sdiff(y2_r, y1_r));
        mul_b = sdiff(x3_r, x1_r);
      end
      OP_M2: begin
        mul_a = m1_r;
        mul_b = sdiff(x3_r, x2_r);
      end
      OP_M3: begin
        mul_a = WW'(sdiff(y3_r, y1_r));
        mul_b = sdiff(x2_r, x1_r);
      end
      OP_M4: begin
        mul_a = m3_r - m1_r;
        mul_b = sdiff(q_r, x2_r);
      end
      OP_M5: begin
        mul_a = acc_r;
        mul_b = sdiff(q_r, x1_r);
      end
      OP_M6: begin
        mul_a = WW'(sdiff(x2_r, x1_r));
        mul_b = sdiff(x3_r, x1_r);
      end
      OP_M7: begin
        mul_a = den_r;
        mul_b = sdiff(x3_r, x2_r);
      end
    endcase
  end

  bpq_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  bpq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign fin_sum = SUM_W'(y1_r) + SUM_W'(div_quo);
  assign fin_ovf = !(&fin_sum[SUM_W-1:DW-1]) && (|fin_sum[SUM_W-1:DW-1]);

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    mul_start = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.kind == KIND_QUERY) begin
          if (n_eff == CNT_W'(1)) begin
            rd_en     = 1'b1;
            state_nxt = S_N1;
          end else if (n_eff <= CNT_W'(3)) begin
            state_nxt = S_TRI;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_N1: begin
        state_nxt = S_HOLD;
      end
      S_SCAN: begin
        if (k_r <= n_r) begin
          rd_en   = 1'b1;
          rd_addr = (k_r == '0) ? nm1[IDX_W-1:0] : km1[IDX_W-1:0];
        end
        if (dval_r && dtag_r == n_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = dec_direct ? S_HOLD : S_TRI;
      end
      S_TRI: begin
        if (k_r <= CNT_W'(2)) begin
          rd_en = 1'b1;
          if (k_r == '0) begin
            rd_addr = ia_r;
          end else if (k_r == CNT_W'(1)) begin
            rd_addr = ib_r;
          end else begin
            rd_addr = ic_r;
          end
        end
        if (dval_r && dtag_r == CNT_W'(2)) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = eval_direct ? S_HOLD : S_MSTART;
      end
      S_MSTART: begin
        mul_start = 1'b1;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (mul_done) begin
          state_nxt = (op_r == OP_LIN || op_r == OP_M7) ? S_DSTART : S_MSTART;
        end
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dval_r  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      dtag_r <= k_r;
    end
    if (state_r == S_IDLE || state_r == S_DECIDE) begin
      k_r <= '0;
    end else if (rd_en) begin
      k_r <= k_r + 1'b1;
    end

    if (state_r == S_IDLE && in_acc) begin
      q_r    <= in_ch.query_x;
      n_r    <= n_eff;
      hit_r  <= 1'b0;
      selv_r <= 1'b0;
      ia_r   <= '0;
      ib_r   <= IDX_W'(1);
      ic_r   <= (n_eff == CNT_W'(2)) ? IDX_W'(1) : IDX_W'(2);
    end

    if (state_r == S_SCAN && dval_r) begin
      if (dtag_r == '0) begin
        xl_r <= rx;
        yl_r <= ry;
      end else if (dtag_r == CNT_W'(1)) begin
        x0_r     <= rx;
        y0_r     <= ry;
        up_r     <= (rx <= xl_r);
        prev_x_r <= rx;
      end else begin
        if (!hit_r && rx == q_r) begin
          hit_r   <= 1'b1;
          hit_y_r <= ry;
        end
        if (up_r ? (q_r > prev_x_r && q_r < rx) : (q_r < prev_x_r && q_r > rx)) begin
          selv_r <= 1'b1;
          sel_r  <= tag_m2[IDX_W-1:0];
        end
        prev_x_r <= rx;
      end
    end

    if (state_r == S_DECIDE) begin
      ia_r <= sel_a;
      ib_r <= sel_a + 1'b1;
      ic_r <= sel_a + IDX_W'(2);
    end

    if (state_r == S_TRI && dval_r) begin
      if (dtag_r == '0) begin
        x1_r <= rx;
        y1_r <= ry;
      end else if (dtag_r == CNT_W'(1)) begin
        x2_r <= rx;
        y2_r <= ry;
      end else begin
        x3_r <= rx;
        y3_r <= ry;
      end
    end

    if (state_r == S_EVAL) begin
      op_r  <= use_lin ? OP_LIN : OP_M1;
      xb_r  <= lxb;
      yb_r  <= lyb;
      den_r <= WW'(sdiff(lxb, x1_r));
    end

    if (state_r == S_MWAIT && mul_done) begin
      unique case (op_r)
        OP_LIN: num_r <= mul_p;
        OP_M1:  m1_r  <= mul_p;
        OP_M2:  acc_r <= mul_p;
        OP_M3:  m3_r  <= mul_p;
        OP_M4:  acc_r <= acc_r + mul_p;
        OP_M5:  num_r <= mul_p;
        OP_M6:  den_r <= mul_p;
        OP_M7:  den_r <= mul_p;
      endcase
      unique case (op_r)
        OP_LIN: op_r <= OP_LIN;
        OP_M1:  op_r <= OP_M2;
        OP_M2:  op_r <= OP_M3;
        OP_M3:  op_r <= OP_M4;
        OP_M4:  op_r <= OP_M5;
        OP_M5:  op_r <= OP_M6;
        OP_M6:  op_r <= OP_M7;
        OP_M7:  op_r <= OP_M7;
      endcase
    end

    if (state_r == S_N1) begin
      res_y_r   <= ry;
      res_sat_r <= 1'b0;
    end else if (state_r == S_DECIDE) begin
      res_y_r   <= dec_y;
      res_sat_r <= 1'b0;
    end else if (state_r == S_EVAL) begin
      res_y_r   <= eval_y;
      res_sat_r <= 1'b0;
    end else if (state_r == S_FIN) begin
      if (fin_ovf) begin
        res_y_r <= fin_sum[SUM_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        res_y_r <= fin_sum[DW-1:0];
      end
      res_sat_r <= fin_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_y_r   <= res_y_r;
      out_sat_r <= res_sat_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.result_y  = out_y_r;
  assign out_ch.saturated = out_sat_r;

endmodule

FILE: design/bpq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/bpq_mul.sv
// Sequential signed multiplier, one bit of the narrow operand per cycle.
// Depends on bpq_pkg.
module bpq_mul import bpq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [WW-1:0]     a,
  input  logic signed [DIFF_W-1:0] b,
  output logic                     done,
  output logic signed [WW-1:0]     p
);

  localparam int MCNT_W = $clog2(DIFF_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [MCNT_W-1:0]    cnt_r;
  logic signed [WW-1:0] acc_r;
  logic signed [WW-1:0] ash_r;
  logic [DIFF_W-1:0]    bm_r;
  logic                 neg_r;
  logic signed [WW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        ash_r  <= a;
        bm_r   <= b[DIFF_W-1] ? DIFF_W'(-b) : DIFF_W'(b);
        neg_r  <= b[DIFF_W-1];
      end else if (busy_r) begin
        if (cnt_r == MCNT_W'(DIFF_W)) begin
          p_r    <= neg_r ? -acc_r : acc_r;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          if (bm_r[0]) begin
            acc_r <= acc_r + ash_r;
          end
          ash_r <= ash_r <<< 1;
          bm_r  <= bm_r >> 1;
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

FILE: design/bpq_div.sv
// Restoring divider, one quotient bit per cycle, rounding half away from zero
// and capping the quotient magnitude. Depends on bpq_pkg.
module bpq_div import bpq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [WW-1:0] num,
  input  logic signed [WW-1:0] den,
  output logic                 done,
  output logic signed [QW-1:0] quo
);

  localparam int DCNT_W = $clog2(WW + 1);
  localparam logic [QCAP_BIT:0] CAP = {1'b1, {QCAP_BIT{1'b0}}};

  logic                 busy_r;
  logic                 done_r;
  logic [DCNT_W-1:0]    cnt_r;
  logic [WW-1:0]        qn_r;
  logic [WW:0]          rem_r;
  logic [WW-1:0]        dm_r;
  logic                 neg_r;
  logic                 dz_r;
  logic signed [QW-1:0] quo_r;

  logic [WW:0]       rem_sh;
  logic              ge;
  logic              rnd;
  logic [WW:0]       qr;
  logic              big;
  logic [QCAP_BIT:0] mag;

  assign rem_sh = {rem_r[WW-1:0], qn_r[WW-1]};
  assign ge     = rem_sh >= {1'b0, dm_r};
  assign rnd    = {rem_r[WW-1:0], 1'b0} >= {1'b0, dm_r};
  assign qr     = {1'b0, qn_r} + (WW+1)'(rnd);
  assign big    = |qr[WW:QCAP_BIT];
  assign mag    = big ? CAP : qr[QCAP_BIT:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        qn_r   <= num[WW-1] ? WW'(-num) : WW'(num);
        dm_r   <= den[WW-1] ? WW'(-den) : WW'(den);
        rem_r  <= '0;
        neg_r  <= num[WW-1] ^ den[WW-1];
        dz_r   <= (den == '0);
      end else if (busy_r) begin
        if (cnt_r == DCNT_W'(WW)) begin
          if (dz_r) begin
            quo_r <= '0;
          end else if (neg_r) begin
            quo_r <= -$signed({1'b0, mag});
          end else begin
            quo_r <= $signed({1'b0, mag});
          end
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          rem_r <= ge ? (rem_sh - {1'b0, dm_r}) : rem_sh;
          qn_r  <= {qn_r[WW-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
